/* sv/tts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

  // Default table size and per-dispatch result limit
  localparam int TASK_SLOTS_DEF = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int CNT_W          = $clog2(MAX_RESULTS);

  // Field widths
  localparam int OP_W    = 2;
  localparam int IDX_W   = 4;
  localparam int TASK_W  = 16;
  localparam int TIME_W  = 16;
  localparam int PEND_W  = 8;
  localparam int SLOT_W  = 5;
  localparam int ERR_W   = 2;

  // Opcodes
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd2;
  localparam logic [OP_W-1:0] OP_DISP = 2'd3;

  // Sticky error codes
  localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL = 2'd1;
  localparam logic [ERR_W-1:0] ERR_DEL  = 2'd2;

  localparam logic [PEND_W-1:0] PEND_MAX = '1;

  // One slot as kept in the table memory
  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] period;
    logic [PEND_W-1:0] pending;
  } entry_t;

endpackage

`default_nettype wire

/* sv/tts_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Request channel
interface tts_in_if;
  logic                        valid;
  logic                        ready;
  logic [tts_pkg::OP_W-1:0]    opcode;
  logic [tts_pkg::IDX_W-1:0]   slot_index;
  logic [tts_pkg::TASK_W-1:0]  task_id;
  logic [tts_pkg::TIME_W-1:0]  first_delay;
  logic [tts_pkg::TIME_W-1:0]  run_period;

  modport source (output valid, opcode, slot_index, task_id, first_delay, run_period,
                  input ready);
  modport sink   (input valid, opcode, slot_index, task_id, first_delay, run_period,
                  output ready);
endinterface

// Result channel
interface tts_out_if;
  logic                        valid;
  logic                        ready;
  logic [tts_pkg::OP_W-1:0]    result_kind;
  logic                        failed;
  logic [tts_pkg::SLOT_W-1:0]  slot_out;
  logic [tts_pkg::TASK_W-1:0]  task_out;
  logic                        task_due;
  logic [tts_pkg::ERR_W-1:0]   error_state;
  logic                        last;

  modport source (output valid, result_kind, failed, slot_out, task_out, task_due,
                  error_state, last, input ready);
  modport sink   (input valid, result_kind, failed, slot_out, task_out, task_due,
                  error_state, last, output ready);
endinterface

`default_nettype wire

/* sv/tts_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* sv/tick_task_scheduler_table.sv */
// Tick: walks every slot in index order, one slot updated per cycle, then gives one result.
// Add, delete, empty dispatch: done at accept; the result goes through ST_RESP to the output register.
// Dispatch: each due slot is read, then emitted and updated once the output register is free.
// One item in flight; the next is taken once its last result is in the output register.
// Reset (async, active low) empties the table through its valid bits and clears the
// sticky error at once; the table memory itself is never swept.
`timescale 1ns / 1ps
`default_nettype none

module tick_task_scheduler_table #(
  parameter int TASK_SLOTS = tts_pkg::TASK_SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tts_in_if.sink    in_i,
  tts_out_if.source out_o
);

  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int EW = $bits(tts_pkg::entry_t);
  localparam logic [SW-1:0] LAST_SLOT = SW'(TASK_SLOTS - 1);
  localparam logic [tts_pkg::SLOT_W-1:0] SLOT_FULL = tts_pkg::SLOT_W'(TASK_SLOTS);
  localparam logic [tts_pkg::CNT_W-1:0] CNT_LAST = tts_pkg::CNT_W'(tts_pkg::MAX_RESULTS - 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_TICK_RD = 3'd1;
  localparam logic [2:0] ST_TICK_EX = 3'd2;
  localparam logic [2:0] ST_DISP_RD = 3'd3;
  localparam logic [2:0] ST_DISP_EX = 3'd4;
  localparam logic [2:0] ST_RESP    = 3'd5;

  logic [2:0]                   state_q, state_d;
  logic [SW-1:0]                s_q, s_d;
  logic [tts_pkg::CNT_W-1:0]    n_q, n_d;
  logic [TASK_SLOTS-1:0]        valid_q, valid_d;
  logic [TASK_SLOTS-1:0]        nz_q, nz_d;      // slot has pending runs
  logic [tts_pkg::ERR_W-1:0]    sticky_q, sticky_d;

  // Single-result response held until the output register is free
  logic [tts_pkg::OP_W-1:0]     rsp_kind_q, rsp_kind_d;
  logic                         rsp_failed_q, rsp_failed_d;
  logic [tts_pkg::SLOT_W-1:0]   rsp_slot_q, rsp_slot_d;

  // Output register
  logic                         ov_q, ov_d;
  logic [tts_pkg::OP_W-1:0]     o_kind_q, o_kind_d;
  logic                         o_failed_q, o_failed_d;
  logic [tts_pkg::SLOT_W-1:0]   o_slot_q, o_slot_d;
  logic [tts_pkg::TASK_W-1:0]   o_task_q, o_task_d;
  logic                         o_due_q, o_due_d;
  logic [tts_pkg::ERR_W-1:0]    o_err_q, o_err_d;
  logic                         o_last_q, o_last_d;

  // Table memory port
  logic                         ram_we, ram_re;
  logic [SW-1:0]                ram_waddr, ram_raddr;
  logic [EW-1:0]                ram_wdata, ram_rdata;
  tts_pkg::entry_t              rd_ent, tick_ent, disp_ent, add_ent;

  logic                         in_acc, out_free;
  logic                         free_found, first_found, nxt_found;
  logic [SW-1:0]                free_idx, first_idx, nxt_idx;
  logic [6:0]                   del_x;
  logic                         del_in_range;
  logic [SW-1:0]                del_slot;
  logic                         disp_last;

  tts_ram #(
    .WIDTH (EW),
    .DEPTH (TASK_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !ov_q || out_o.ready;

  assign rd_ent = tts_pkg::entry_t'(ram_rdata);

  // Lowest free slot, lowest slot with runs, next slot with runs above the cursor
  always_comb begin
    free_found  = 1'b0;
    free_idx    = '0;
    first_found = 1'b0;
    first_idx   = '0;
    nxt_found   = 1'b0;
    nxt_idx     = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
      if (nz_q[i]) begin
        first_found = 1'b1;
        first_idx   = SW'(i);
      end
      if (nz_q[i] && (i > int'(s_q))) begin
        nxt_found = 1'b1;
        nxt_idx   = SW'(i);
      end
    end
  end

  // Delete index range check
  assign del_x        = {3'b000, in_i.slot_index};
  assign del_in_range = (int'(del_x) < TASK_SLOTS);
  assign del_slot     = SW'(del_x);

  // Tick update of one slot
  always_comb begin
    tick_ent = rd_ent;
    if (rd_ent.delay == '0) begin
      if (rd_ent.pending != tts_pkg::PEND_MAX) begin
        tick_ent.pending = rd_ent.pending + tts_pkg::PEND_W'(1);
      end
      tick_ent.delay = rd_ent.period;
    end else begin
      tick_ent.delay = rd_ent.delay - tts_pkg::TIME_W'(1);
    end
  end

  // Dispatch update of one slot
  always_comb begin
    disp_ent         = rd_ent;
    disp_ent.pending = rd_ent.pending - tts_pkg::PEND_W'(1);
  end

  assign add_ent   = '{task_id: in_i.task_id, delay: in_i.first_delay,
                       period: in_i.run_period, pending: '0};
  assign disp_last = !nxt_found || (n_q == CNT_LAST);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    s_d          = s_q;
    n_d          = n_q;
    valid_d      = valid_q;
    nz_d         = nz_q;
    sticky_d     = sticky_q;
    rsp_kind_d   = rsp_kind_q;
    rsp_failed_d = rsp_failed_q;
    rsp_slot_d   = rsp_slot_q;
    ov_d         = ov_q;
    o_kind_d     = o_kind_q;
    o_failed_d   = o_failed_q;
    o_slot_d     = o_slot_q;
    o_task_d     = o_task_q;
    o_due_d      = o_due_q;
    o_err_d      = o_err_q;
    o_last_d     = o_last_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = s_q;
    ram_raddr    = s_q;
    ram_wdata    = '0;

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          rsp_kind_d   = in_i.opcode;
          rsp_failed_d = 1'b0;
          rsp_slot_d   = '0;
          case (in_i.opcode)
            tts_pkg::OP_TICK: begin
              s_d     = '0;
              state_d = ST_TICK_RD;
            end
            tts_pkg::OP_ADD: begin
              state_d = ST_RESP;
              if (free_found) begin
                ram_we            = 1'b1;
                ram_waddr         = free_idx;
                ram_wdata         = add_ent;
                valid_d[free_idx] = 1'b1;
                nz_d[free_idx]    = 1'b0;
                rsp_slot_d        = tts_pkg::SLOT_W'(free_idx);
              end else begin
                sticky_d     = tts_pkg::ERR_FULL;
                rsp_failed_d = 1'b1;
                rsp_slot_d   = SLOT_FULL;
              end
            end
            tts_pkg::OP_DEL: begin
              state_d    = ST_RESP;
              rsp_slot_d = tts_pkg::SLOT_W'(in_i.slot_index);
              if (del_in_range && valid_q[del_slot]) begin
                valid_d[del_slot] = 1'b0;
                nz_d[del_slot]    = 1'b0;
              end else begin
                sticky_d     = tts_pkg::ERR_DEL;
                rsp_failed_d = 1'b1;
              end
            end
            default: begin
              if (first_found) begin
                s_d     = first_idx;
                n_d     = '0;
                state_d = ST_DISP_RD;
              end else begin
                state_d = ST_RESP;
              end
            end
          endcase
        end
      end

      ST_TICK_RD: begin
        ram_re  = 1'b1;
        state_d = ST_TICK_EX;
      end

      // Update slot s_q while reading the next one
      ST_TICK_EX: begin
        if (valid_q[s_q]) begin
          ram_we    = 1'b1;
          ram_wdata = tick_ent;
          nz_d[s_q] = (tick_ent.pending != '0);
        end
        if (s_q == LAST_SLOT) begin
          state_d = ST_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = s_q + SW'(1);
          s_d       = s_q + SW'(1);
        end
      end

      ST_DISP_RD: begin
        ram_re  = 1'b1;
        state_d = ST_DISP_EX;
      end

      // Emit one due slot, then retire one run
      ST_DISP_EX: begin
        if (out_free) begin
          ov_d       = 1'b1;
          o_kind_d   = tts_pkg::OP_DISP;
          o_failed_d = 1'b0;
          o_slot_d   = tts_pkg::SLOT_W'(s_q);
          o_task_d   = rd_ent.task_id;
          o_due_d    = 1'b1;
          o_err_d    = sticky_q;
          o_last_d   = disp_last;
          ram_we     = 1'b1;
          ram_wdata  = disp_ent;
          if (rd_ent.period == '0) begin
            valid_d[s_q] = 1'b0;
            nz_d[s_q]    = 1'b0;
          end else begin
            nz_d[s_q] = (disp_ent.pending != '0);
          end
          if (disp_last) begin
            state_d = ST_IDLE;
          end else begin
            s_d     = nxt_idx;
            n_d     = n_q + tts_pkg::CNT_W'(1);
            state_d = ST_DISP_RD;
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          ov_d       = 1'b1;
          o_kind_d   = rsp_kind_q;
          o_failed_d = rsp_failed_q;
          o_slot_d   = rsp_slot_q;
          o_task_d   = '0;
          o_due_d    = 1'b0;
          o_err_d    = sticky_q;
          o_last_d   = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      s_q      <= '0;
      n_q      <= '0;
      valid_q  <= '0;
      nz_q     <= '0;
      sticky_q <= tts_pkg::ERR_NONE;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      s_q      <= s_d;
      n_q      <= n_d;
      valid_q  <= valid_d;
      nz_q     <= nz_d;
      sticky_q <= sticky_d;
      ov_q     <= ov_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    rsp_kind_q   <= rsp_kind_d;
    rsp_failed_q <= rsp_failed_d;
    rsp_slot_q   <= rsp_slot_d;
    o_kind_q     <= o_kind_d;
    o_failed_q   <= o_failed_d;
    o_slot_q     <= o_slot_d;
    o_task_q     <= o_task_d;
    o_due_q      <= o_due_d;
    o_err_q      <= o_err_d;
    o_last_q     <= o_last_d;
  end

  assign out_o.valid       = ov_q;
  assign out_o.result_kind = o_kind_q;
  assign out_o.failed      = o_failed_q;
  assign out_o.slot_out    = o_slot_q;
  assign out_o.task_out    = o_task_q;
  assign out_o.task_due    = o_due_q;
  assign out_o.error_state = o_err_q;
  assign out_o.last        = o_last_q;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import tts_pkg::*;

  localparam int TASK_SLOTS  = TASK_SLOTS_DEF;
  localparam int RANDOM_REQS = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 2 * TASK_SLOTS + 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SHOW_LIMIT  = 10;

  // One result as seen on the output channel
  typedef struct packed {
    logic [OP_W-1:0]   kind;
    logic              failed;
    logic [SLOT_W-1:0] slot;
    logic [TASK_W-1:0] tid;
    logic              due;
    logic [ERR_W-1:0]  err;
    logic              last;
  } sched_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tts_in_if  in_if ();
  tts_out_if out_if ();

  tick_task_scheduler_table #(
    .TASK_SLOTS(TASK_SLOTS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Clock
  always #1 clk_i = ~clk_i;

  // Scheduler table as predicted
  logic [TASK_SLOTS-1:0] slot_live;
  logic [TASK_W-1:0]     slot_tid   [TASK_SLOTS];
  logic [TIME_W-1:0]     slot_wait  [TASK_SLOTS];
  logic [TIME_W-1:0]     slot_every [TASK_SLOTS];
  logic [PEND_W-1:0]     slot_runs  [TASK_SLOTS];
  logic [ERR_W-1:0]      sticky_err;

  sched_result_t awaited_results[$];

  int  fail_count;
  int  shown_count;
  int  cycle_count;
  bit  calm;
  bit  hold_req;
  int  hold_left;

  // Predict the results of one accepted request and update the table
  function automatic void schedule_step(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                        logic [TASK_W-1:0] tid, logic [TIME_W-1:0] dly,
                                        logic [TIME_W-1:0] per);
    sched_result_t res;
    int            free_slot;
    int            n;
    logic          bad;
    res = '0;
    res.kind = op;
    case (op)
      OP_TICK: begin
        for (int s = 0; s < TASK_SLOTS; s++) begin
          if (slot_live[s]) begin
            if (slot_wait[s] == '0) begin
              if (slot_runs[s] != PEND_MAX) slot_runs[s]++;
              if (slot_every[s] != '0) slot_wait[s] = slot_every[s];
            end else begin
              slot_wait[s]--;
            end
          end
        end
        res.err  = sticky_err;
        res.last = 1'b1;
        awaited_results.push_back(res);
      end
      OP_ADD: begin
        free_slot = -1;
        for (int s = TASK_SLOTS - 1; s >= 0; s--) begin
          if (!slot_live[s]) free_slot = s;
        end
        if (free_slot < 0) begin
          sticky_err = ERR_FULL;
          res.failed = 1'b1;
          res.slot   = SLOT_W'(TASK_SLOTS);
        end else begin
          slot_live[free_slot]  = 1'b1;
          slot_tid[free_slot]   = tid;
          slot_wait[free_slot]  = dly;
          slot_every[free_slot] = per;
          slot_runs[free_slot]  = '0;
          res.slot = SLOT_W'(free_slot);
        end
        res.err  = sticky_err;
        res.last = 1'b1;
        awaited_results.push_back(res);
      end
      OP_DEL: begin
        bad = !slot_live[idx];
        slot_live[idx]  = 1'b0;
        slot_tid[idx]   = '0;
        slot_wait[idx]  = '0;
        slot_every[idx] = '0;
        slot_runs[idx]  = '0;
        if (bad) sticky_err = ERR_DEL;
        res.failed = bad;
        res.slot   = SLOT_W'(idx);
        res.err    = sticky_err;
        res.last   = 1'b1;
        awaited_results.push_back(res);
      end
      default: begin
        // dispatch: one result per slot with runs pending, in index order
        n = 0;
        for (int s = 0; s < TASK_SLOTS; s++) begin
          if (slot_runs[s] != '0 && n < MAX_RESULTS) begin
            res.slot = SLOT_W'(s);
            res.tid  = slot_tid[s];
            res.due  = 1'b1;
            res.err  = sticky_err;
            res.last = 1'b0;
            awaited_results.push_back(res);
            n++;
            slot_runs[s]--;
            // one-shot slots leave the table once run
            if (slot_every[s] == '0) begin
              slot_live[s]  = 1'b0;
              slot_tid[s]   = '0;
              slot_wait[s]  = '0;
              slot_runs[s]  = '0;
            end
          end
        end
        if (n == 0) begin
          res.err  = sticky_err;
          res.last = 1'b1;
          awaited_results.push_back(res);
        end else begin
          awaited_results[awaited_results.size() - 1].last = 1'b1;
        end
      end
    endcase
  endfunction

  // Offer one request; valid stays up after accept until the next falling edge
  task automatic issue_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                               logic [TASK_W-1:0] tid, logic [TIME_W-1:0] dly,
                               logic [TIME_W-1:0] per);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 31) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= op;
    in_if.slot_index  <= idx;
    in_if.task_id     <= tid;
    in_if.first_delay <= dly;
    in_if.run_period  <= per;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    schedule_step(op, idx, tid, dly, per);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(0, 99) >= 31);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    sched_result_t got;
    sched_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.kind   = out_if.result_kind;
      got.failed = out_if.failed;
      got.slot   = out_if.slot_out;
      got.tid    = out_if.task_out;
      got.due    = out_if.task_due;
      got.err    = out_if.error_state;
      got.last   = out_if.last;
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (shown_count < SHOW_LIMIT) begin
          shown_count++;
          $display("unexpected result: kind=%0d failed=%0d slot=%0d id=%h due=%0d err=%0d last=%0d",
                   got.kind, got.failed, got.slot, got.tid, got.due, got.err, got.last);
        end
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (shown_count < SHOW_LIMIT) begin
            shown_count++;
            $display("mismatch exp: kind=%0d failed=%0d slot=%0d id=%h due=%0d err=%0d last=%0d",
                     want.kind, want.failed, want.slot, want.tid, want.due, want.err,
                     want.last);
            $display("         act: kind=%0d failed=%0d slot=%0d id=%h due=%0d err=%0d last=%0d",
                     got.kind, got.failed, got.slot, got.tid, got.due, got.err, got.last);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Empty table: nothing due, tick on nothing, delete of empty slots
  task automatic test_empty_table();
    issue_request(OP_DISP, 4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue_request(OP_TICK, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue_request(OP_DEL, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    issue_request(OP_DEL, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
  endtask

  // A one-shot task at zero delay gains a run per tick; count must stop at max
  task automatic test_pending_saturation();
    issue_request(OP_ADD, 4'd0, 16'h1234, 16'h0000, 16'h0001);
    issue_request(OP_ADD, 4'd0, 16'hFFFF, 16'h0000, 16'h0000);
    repeat (256) issue_request(OP_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    issue_request(OP_DISP, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    issue_request(OP_DEL, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    issue_request(OP_DISP, 4'd0, 16'h0000, 16'h0000, 16'h0000);
  endtask

  // Fill every slot, overflow, then run, free and refill
  task automatic test_fill_and_overflow();
    logic [TASK_W-1:0] tid;
    logic [TIME_W-1:0] dly;
    logic [TIME_W-1:0] per;
    for (int s = 0; s < TASK_SLOTS; s++) begin
      tid = 16'($urandom);
      dly = 16'(s % 3);
      per = 16'(s % 4);
      case (s)
        0: begin tid = 16'h0000; dly = 16'h0000; per = 16'h0000; end
        1: begin tid = 16'hFFFF; dly = 16'h0000; per = 16'hFFFF; end
        2: begin dly = 16'hFFFF; per = 16'h0000; end
        3: begin dly = 16'h0001; per = 16'h0001; end
        default: ;
      endcase
      issue_request(OP_ADD, 4'(s), tid, dly, per);
    end
    issue_request(OP_ADD, 4'hF, 16'hA5A5, 16'h0001, 16'h0001);
    issue_request(OP_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    issue_request(OP_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    issue_request(OP_DISP, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    issue_request(OP_DISP, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    issue_request(OP_DEL, 4'd2, 16'h0000, 16'h0000, 16'h0000);
    issue_request(OP_DEL, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    issue_request(OP_ADD, 4'd0, 16'h5A5A, 16'h0000, 16'h0002);
    issue_request(OP_DISP, 4'd0, 16'h0000, 16'h0000, 16'h0000);
  endtask

  // Random mix of operations; deletes mostly aim at live slots
  task automatic test_random_mix();
    int                r;
    int                live_list[$];
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] dly;
    logic [TIME_W-1:0] per;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      calm = (i >= 40 && i < 65);
      if (i == 15 || i == 80) hold_req = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 40) op = OP_TICK;
      else if (r < 65) op = OP_ADD;
      else if (r < 82) op = OP_DEL;
      else op = OP_DISP;
      idx = 4'($urandom);
      if (op == OP_DEL && $urandom_range(0, 99) < 80) begin
        live_list.delete();
        for (int s = 0; s < TASK_SLOTS; s++) if (slot_live[s]) live_list.push_back(s);
        if (live_list.size() != 0)
          idx = 4'(live_list[$urandom_range(0, live_list.size() - 1)]);
      end
      dly = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      if (r < 10) per = 16'($urandom);
      else if (r < 35) per = '0;
      else per = 16'($urandom_range(1, 5));
      issue_request(op, idx, 16'($urandom), dly, per);
    end
    calm = 1'b0;
  endtask

  // Main sequence
  initial begin
    fail_count  = 0;
    shown_count = 0;
    cycle_count = 0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    hold_left   = 0;
    slot_live   = '0;
    sticky_err  = ERR_NONE;
    for (int s = 0; s < TASK_SLOTS; s++) begin
      slot_tid[s]   = '0;
      slot_wait[s]  = '0;
      slot_every[s] = '0;
      slot_runs[s]  = '0;
    end
    in_if.valid       = 1'b0;
    in_if.opcode      = OP_TICK;
    in_if.slot_index  = '0;
    in_if.task_id     = '0;
    in_if.first_delay = '0;
    in_if.run_period  = '0;
    out_if.ready      = 1'b0;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_pending_saturation();
    test_fill_and_overflow();
    test_random_mix();

    @(negedge clk_i);
    in_if.valid <= 1'b0;

    // drain, then allow for any stray output
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    fail_count += awaited_results.size();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
